FILE: src/lpn_pkg.sv
// Shared types and constants for the length-prefixed NAL to start-code converter.
// Used by every module under src; depends on nothing.
package lpn_pkg;

    // Depth of the command queue between the parser and the emitter
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Start code bytes 00 00 00 01
    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;

    // Header record layout: index of the last byte dropped before the SPS length
    localparam logic [2:0] HDR_SKIP_LAST = 3'd5;
    // Last byte index of a 4-byte length prefix
    localparam logic [1:0] PFX_LAST      = 2'd3;

    // Input word
    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_of_buffer;
        logic       end_of_buffer;
        logic       payload_kind;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_end;
        logic       truncated;
    } t_out_word;

    // Command kinds handed from parser to emitter
    typedef enum logic [1:0] {
        OP_NONE,
        OP_BYTE,
        OP_CODE
    } t_op;

    // One queued command: a single byte, or a 4-byte start code with flags on its last byte
    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       last;
        logic       trunc;
    } t_cmd;

endpackage

FILE: src/length_prefixed_nal_to_start_codes.sv
// Length-prefixed NAL to start-code converter, top level.
// Throughput: one input word per cycle; a header start code expands into 4 output
// words, absorbed by a 4-entry command queue, so input stalls only when it fills.
// Reset: synchronous active-low i_rst_n clears parser state, queue and output valid.
// Depends on lpn_pkg, lpn_front, lpn_queue, lpn_back.
module length_prefixed_nal_to_start_codes (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  lpn_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output lpn_pkg::t_out_word o_data
);
    import lpn_pkg::*;

    logic full, push, pop, avail;
    t_cmd push_cmd, head;

    // Parser
    lpn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_full  (full),
        .o_stall (o_stall),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // Command queue
    lpn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_avail (avail),
        .o_head  (head)
    );

    // Emitter
    lpn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

FILE: src/lpn_front.sv
// Parser: accepts input words, tracks buffer layout and issues emit commands.
// Depends on lpn_pkg.
module lpn_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  lpn_pkg::t_in_word i_data,
    input  logic              i_full,
    output logic              o_stall,
    output logic              o_push,
    output lpn_pkg::t_cmd     o_cmd
);
    import lpn_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_PREFIX,
        PH_PAYLOAD,
        PH_SKIP,
        PH_SPS_HI,
        PH_SPS_LO,
        PH_SPS,
        PH_GAP,
        PH_PPS_HI,
        PH_PPS_LO,
        PH_PPS,
        PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_kind,  n_kind;
    logic [2:0]  r_hpos,  n_hpos;
    logic [31:0] r_acc,   n_acc;
    logic [31:0] r_rem,   n_rem;
    t_cmd        cmd;
    logic        accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && (cmd.op != OP_NONE);
    assign o_cmd   = cmd;

    // Next state and command for the word at the input
    always_comb begin
        logic [31:0] shifted;
        logic [15:0] len16;
        n_phase = r_phase;
        n_kind  = r_kind;
        n_hpos  = r_hpos;
        n_acc   = r_acc;
        n_rem   = r_rem;
        cmd     = '{op: OP_NONE, data: SC_ZERO, last: 1'b0, trunc: 1'b0};

        // start mark restarts parsing on this word
        if (i_data.start_of_buffer) begin
            n_kind  = i_data.payload_kind;
            n_hpos  = '0;
            n_acc   = '0;
            n_rem   = '0;
            n_phase = i_data.payload_kind ? PH_SKIP : PH_PREFIX;
        end

        shifted = {n_acc[23:0], i_data.in_byte};
        len16   = {n_acc[7:0], i_data.in_byte};

        unique case (n_phase)
            PH_PREFIX: begin
                cmd.op   = OP_BYTE;
                cmd.data = (n_hpos[1:0] == PFX_LAST) ? SC_ONE : SC_ZERO;
                n_acc    = shifted;
                n_hpos   = n_hpos + 3'd1;
                if (n_hpos[1:0] == PFX_LAST + 2'd1 && n_hpos[2] == 1'b1) begin
                    n_rem   = shifted;
                    n_acc   = '0;
                    n_hpos  = '0;
                    n_phase = (shifted != 32'd0) ? PH_PAYLOAD : PH_PREFIX;
                end
            end
            PH_PAYLOAD: begin
                cmd.op   = OP_BYTE;
                cmd.data = i_data.in_byte;
                n_rem    = n_rem - 32'd1;
                if (n_rem == 32'd0) n_phase = PH_PREFIX;
            end
            PH_SKIP: begin
                if (n_hpos == HDR_SKIP_LAST) begin
                    n_hpos  = '0;
                    n_phase = PH_SPS_HI;
                end else begin
                    n_hpos = n_hpos + 3'd1;
                end
            end
            PH_SPS_HI: begin
                n_acc   = {24'd0, i_data.in_byte};
                n_phase = PH_SPS_LO;
            end
            PH_SPS_LO: begin
                n_rem   = {16'd0, len16};
                n_acc   = '0;
                cmd.op  = OP_CODE;
                n_phase = (len16 != 16'd0) ? PH_SPS : PH_GAP;
            end
            PH_SPS: begin
                cmd.op   = OP_BYTE;
                cmd.data = i_data.in_byte;
                n_rem    = n_rem - 32'd1;
                if (n_rem == 32'd0) n_phase = PH_GAP;
            end
            PH_GAP: begin
                n_phase = PH_PPS_HI;
            end
            PH_PPS_HI: begin
                n_acc   = {24'd0, i_data.in_byte};
                n_phase = PH_PPS_LO;
            end
            PH_PPS_LO: begin
                n_rem  = {16'd0, len16};
                n_acc  = '0;
                cmd.op = OP_CODE;
                if (len16 == 16'd0) begin
                    cmd.last = 1'b1;
                    n_phase  = PH_DONE;
                end else begin
                    n_phase = PH_PPS;
                end
            end
            PH_PPS: begin
                n_rem    = n_rem - 32'd1;
                cmd.op   = OP_BYTE;
                cmd.data = i_data.in_byte;
                cmd.last = (n_rem == 32'd0);
                if (n_rem == 32'd0) n_phase = PH_DONE;
            end
            default: begin
                // idle or header complete: nothing emitted
            end
        endcase

        // end mark closes an open buffer
        if (i_data.end_of_buffer && n_phase != PH_IDLE) begin
            if (!n_kind) begin
                if (cmd.op != OP_NONE) cmd.last = 1'b1;
            end else if (n_phase != PH_DONE) begin
                if (cmd.op != OP_NONE) begin
                    cmd.last  = 1'b1;
                    cmd.trunc = 1'b1;
                end else begin
                    cmd = '{op: OP_BYTE, data: SC_ZERO, last: 1'b1, trunc: 1'b1};
                end
            end
            n_phase = PH_IDLE;
            n_hpos  = '0;
            n_acc   = '0;
            n_rem   = '0;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_kind  <= 1'b0;
            r_hpos  <= '0;
            r_acc   <= '0;
            r_rem   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_hpos  <= n_hpos;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
        end
    end

endmodule

FILE: src/lpn_queue.sv
// Small command FIFO between parser and emitter, held in flip-flops.
// Depends on lpn_pkg.
module lpn_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lpn_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_avail,
    output lpn_pkg::t_cmd o_head
);
    import lpn_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr, r_rptr;
    logic [QAW:0]   r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_avail = (r_count != '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_cmd;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + 1'b1;
            if (do_pop)  r_rptr <= r_rptr + 1'b1;
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: src/lpn_back.sv
// Emitter: expands queued commands into output words behind an output register.
// Depends on lpn_pkg.
module lpn_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_avail,
    input  lpn_pkg::t_cmd      i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output lpn_pkg::t_out_word o_data
);
    import lpn_pkg::*;

    logic       r_valid;
    t_out_word  r_data;
    logic [1:0] r_cnt;
    logic       load, code_last;
    t_out_word  n_data;

    assign o_valid   = r_valid;
    assign o_data    = r_data;
    assign load      = i_avail && (!r_valid || !i_stall);
    assign code_last = (r_cnt == PFX_LAST);
    assign o_pop     = load && ((i_head.op != OP_CODE) || code_last);

    // Word for the head command at the current start-code position
    always_comb begin
        unique case (i_head.op)
            OP_CODE: begin
                n_data.out_byte  = code_last ? SC_ONE : SC_ZERO;
                n_data.out_end   = code_last && i_head.last;
                n_data.truncated = code_last && i_head.trunc;
            end
            default: begin
                n_data.out_byte  = i_head.data;
                n_data.out_end   = i_head.last;
                n_data.truncated = i_head.trunc;
            end
        endcase
    end

    // Output register and start-code counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_cnt   <= o_pop ? 2'd0 : r_cnt + 2'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_data <= n_data;
    end

endmodule

FILE: bench/length_prefixed_nal_to_start_codes_tb.sv
// Testbench for the length-prefixed NAL to start-code converter.
// Holds a scoreboard class with its own parser model; depends on lpn_pkg and the top level.
`timescale 1ns / 100ps

import lpn_pkg::*;

// Parser phases of the model, in buffer order
typedef enum logic [3:0] {
    PS_IDLE,
    PS_PREFIX,
    PS_PAYLOAD,
    PS_SKIP,
    PS_SPS_HI,
    PS_SPS_LO,
    PS_SPS,
    PS_GAP,
    PS_PPS_HI,
    PS_PPS_LO,
    PS_PPS,
    PS_DONE
} t_parse_state;

localparam int PREFIX_BYTES   = 4;
localparam int HDR_SKIP_BYTES = 6;
localparam int CODE_BYTES     = 4;

// Predicts the converted words for each accepted input word and checks the outputs
class start_code_scoreboard;
    t_parse_state state;
    bit           hdr_kind;
    bit [2:0]     pos;
    bit [31:0]    len_acc;
    bit [31:0]    remain;
    t_out_word    expected_q[$];
    t_out_word    step_res[CODE_BYTES];
    int           step_n;
    int           errors;
    int           matched;

    function new();
        state    = PS_IDLE;
        hdr_kind = 1'b0;
        pos      = '0;
        len_acc  = '0;
        remain   = '0;
        errors   = 0;
        matched  = 0;
    endfunction

    function void emit(logic [7:0] b, logic e, logic t);
        step_res[step_n].out_byte  = b;
        step_res[step_n].out_end   = e;
        step_res[step_n].truncated = t;
        step_n++;
    endfunction

    function void emit_code();
        for (int k = 0; k < CODE_BYTES; k++)
            emit((k == CODE_BYTES - 1) ? SC_ONE : SC_ZERO, 1'b0, 1'b0);
    endfunction

    // Advance the parser by one accepted word and queue what it produces
    function void note_word(t_in_word w);
        step_n = 0;
        if (w.start_of_buffer) begin
            hdr_kind = w.payload_kind;
            pos      = '0;
            len_acc  = '0;
            remain   = '0;
            state    = w.payload_kind ? PS_SKIP : PS_PREFIX;
        end
        if (state == PS_IDLE)
            return;

        case (state)
            PS_PREFIX: begin
                emit((pos == PREFIX_BYTES - 1) ? SC_ONE : SC_ZERO, 1'b0, 1'b0);
                len_acc = {len_acc[23:0], w.in_byte};
                pos     = pos + 3'd1;
                if (pos >= PREFIX_BYTES) begin
                    remain  = len_acc;
                    len_acc = '0;
                    pos     = '0;
                    state   = (remain != 0) ? PS_PAYLOAD : PS_PREFIX;
                end
            end
            PS_PAYLOAD: begin
                emit(w.in_byte, 1'b0, 1'b0);
                remain--;
                if (remain == 0)
                    state = PS_PREFIX;
            end
            PS_SKIP: begin
                pos = pos + 3'd1;
                if (pos >= HDR_SKIP_BYTES) begin
                    pos   = '0;
                    state = PS_SPS_HI;
                end
            end
            PS_SPS_HI: begin
                len_acc = {24'd0, w.in_byte};
                state   = PS_SPS_LO;
            end
            PS_SPS_LO: begin
                remain  = {16'd0, len_acc[7:0], w.in_byte};
                len_acc = '0;
                emit_code();
                state   = (remain != 0) ? PS_SPS : PS_GAP;
            end
            PS_SPS: begin
                emit(w.in_byte, 1'b0, 1'b0);
                remain--;
                if (remain == 0)
                    state = PS_GAP;
            end
            PS_GAP: state = PS_PPS_HI;
            PS_PPS_HI: begin
                len_acc = {24'd0, w.in_byte};
                state   = PS_PPS_LO;
            end
            PS_PPS_LO: begin
                remain  = {16'd0, len_acc[7:0], w.in_byte};
                len_acc = '0;
                emit_code();
                // empty PPS: the code's last byte closes the header
                if (remain == 0) begin
                    step_res[step_n - 1].out_end = 1'b1;
                    state = PS_DONE;
                end else begin
                    state = PS_PPS;
                end
            end
            PS_PPS: begin
                remain--;
                emit(w.in_byte, remain == 0, 1'b0);
                if (remain == 0)
                    state = PS_DONE;
            end
            default: ;
        endcase

        // Buffer end: mark the last word, flag a short header
        if (w.end_of_buffer) begin
            if (!hdr_kind) begin
                if (step_n > 0)
                    step_res[step_n - 1].out_end = 1'b1;
            end else if (state != PS_DONE) begin
                if (step_n > 0) begin
                    step_res[step_n - 1].out_end   = 1'b1;
                    step_res[step_n - 1].truncated = 1'b1;
                end else begin
                    emit(8'h00, 1'b1, 1'b1);
                end
            end
            state   = PS_IDLE;
            pos     = '0;
            len_acc = '0;
            remain  = '0;
        end

        for (int k = 0; k < step_n; k++)
            expected_q.push_back(step_res[k]);
    endfunction

    // Compare one accepted output word with the oldest prediction
    function void check_word(t_out_word got);
        t_out_word exp_w;
        if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected output word: byte %02h end %0b trunc %0b",
                     $time, got.out_byte, got.out_end, got.truncated);
            return;
        end
        exp_w = expected_q.pop_front();
        if (got.out_byte !== exp_w.out_byte || got.out_end !== exp_w.out_end ||
            got.truncated !== exp_w.truncated) begin
            errors++;
            $display("%0t: mismatch: expected byte %02h end %0b trunc %0b,",
                     $time, exp_w.out_byte, exp_w.out_end, exp_w.truncated,
                     " got byte %02h end %0b trunc %0b",
                     got.out_byte, got.out_end, got.truncated);
        end else begin
            matched++;
        end
    endfunction
endclass

module length_prefixed_nal_to_start_codes_tb;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int HOLD_CYCLES  = 48;
    localparam int TAIL_CYCLES  = 16;
    localparam int PHASE_BYTES  = 16;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_word  i_data  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_word o_data;

    start_code_scoreboard sb = new();

    int        send_idle_pct   = 0;
    int        recv_stall_pct  = 0;
    int        holds_requested = 0;
    int        holds_granted   = 0;
    int        hold_left       = 0;
    int        cycle_count     = 0;
    int        bytes_sent      = 0;
    int        frames_sent     = 0;
    logic [7:0] frame_bytes[$];

    length_prefixed_nal_to_start_codes dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #1 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, sb.expected_q.size());
            $display("length_prefixed_nal_to_start_codes test failed");
            $finish;
        end
    end

    // Output side: check accepted words, random stall, long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                sb.check_word(o_data);
            if (holds_granted != holds_requested) begin
                holds_granted++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Offer one word with random idle cycles ahead of it; return once accepted
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sb.note_word(w);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit sob, input bit eob, input bit kind);
        t_in_word w;
        w.in_byte         = b;
        w.start_of_buffer = sob;
        w.end_of_buffer   = eob;
        w.payload_kind    = kind;
        send_word(w);
    endtask

    // Send the first cut bytes of frame_bytes as one buffer
    task automatic send_frame(input bit kind, input int cut, input bit mark_end);
        for (int i = 0; i < cut; i++)
            send_byte(frame_bytes[i], i == 0, mark_end && (i == cut - 1),
                      (i == 0) ? kind : 1'($urandom_range(1)));
        bytes_sent += cut;
        frames_sent++;
    endtask

    // NAL stream: a few units, each behind a big-endian 4-byte length
    function automatic void build_stream();
        int units;
        bit [31:0] len;
        frame_bytes.delete();
        units = $urandom_range(3, 1);
        for (int u = 0; u < units; u++) begin
            len = $urandom_range(99) < 15 ? 0 : $urandom_range(6, 1);
            for (int k = PREFIX_BYTES - 1; k >= 0; k--)
                frame_bytes.push_back(len[8*k +: 8]);
            for (int i = 0; i < len; i++)
                frame_bytes.push_back(8'($urandom));
        end
    endfunction

    // Parameter-set header: skipped bytes, SPS, gap byte, PPS, trailing bytes
    function automatic void build_header(input int max_len);
        bit [15:0] len;
        int trail;
        frame_bytes.delete();
        for (int i = 0; i < HDR_SKIP_BYTES; i++)
            frame_bytes.push_back(8'($urandom));
        for (int s = 0; s < 2; s++) begin
            len = 16'($urandom_range(max_len));
            frame_bytes.push_back(len[15:8]);
            frame_bytes.push_back(len[7:0]);
            for (int i = 0; i < len; i++)
                frame_bytes.push_back(8'($urandom));
            if (s == 0)
                frame_bytes.push_back(8'($urandom));
        end
        trail = $urandom_range(2);
        for (int i = 0; i < trail; i++)
            frame_bytes.push_back(8'($urandom));
    endfunction

    // Raw words with random marks
    task automatic send_noise();
        int count;
        count = $urandom_range(6, 1);
        for (int i = 0; i < count; i++)
            send_byte(8'($urandom), $urandom_range(99) < 30, $urandom_range(99) < 30,
                      1'($urandom_range(1)));
    endtask

    // Mostly well-formed buffers, some cut short or left open, some noise
    task automatic run_random(input int byte_goal);
        int goal;
        int choice;
        int cut;
        bit mark_end;
        bit kind;
        goal = bytes_sent + byte_goal;
        while (bytes_sent < goal) begin
            choice = $urandom_range(99);
            if (choice < 10) begin
                send_noise();
            end else begin
                kind = (choice < 55);
                if (kind)
                    build_header(5);
                else
                    build_stream();
                cut      = frame_bytes.size();
                mark_end = 1'b1;
                if ($urandom_range(99) < 20) begin
                    cut      = $urandom_range(frame_bytes.size(), 1);
                    mark_end = 1'($urandom_range(1));
                end
                send_frame(kind, cut, mark_end);
            end
        end
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: stray word, abandoned header, stream with empty NAL
        send_byte(8'hFF, 1'b0, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0, 1'b1);
        send_byte(8'hA5, 1'b0, 1'b0, 1'b0);
        send_byte(8'h5A, 1'b0, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0, 1'b0);
        repeat (3) send_byte(8'h00, 1'b0, 1'b0, 1'b0);
        repeat (3) send_byte(8'h00, 1'b0, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0, 1'b0);
        // stream ends inside the next prefix
        send_byte(8'h00, 1'b0, 1'b1, 1'b0);

        // Header with empty SPS and PPS, then a trailing end word
        send_byte(8'hFF, 1'b1, 1'b0, 1'b1);
        for (int i = 0; i < HDR_SKIP_BYTES - 1; i++)
            send_byte(i[0] ? 8'hFF : 8'h00, 1'b0, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0, 1'b0);
        send_byte(8'h7E, 1'b0, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0, 1'b0);
        send_byte(8'h33, 1'b0, 1'b1, 1'b0);

        // Header ending on its first word gives the empty error word
        send_byte(8'h80, 1'b1, 1'b1, 1'b1);
        wait_drain();

        // Random phases with different idling on each side
        send_idle_pct = 0;  recv_stall_pct = 0;
        run_random(PHASE_BYTES);
        wait_drain();
        send_idle_pct = 59; recv_stall_pct = 0;
        run_random(PHASE_BYTES);
        wait_drain();
        send_idle_pct = 0;  recv_stall_pct = 59;
        run_random(PHASE_BYTES);
        wait_drain();
        send_idle_pct = 21; recv_stall_pct = 21;
        run_random(PHASE_BYTES);
        wait_drain();

        // Back-pressure: output held off while a code-heavy header streams in
        send_idle_pct = 0;  recv_stall_pct = 0;
        holds_requested++;
        build_header(12);
        send_frame(1'b1, frame_bytes.size(), 1'b1);
        build_stream();
        send_frame(1'b0, frame_bytes.size(), 1'b1);
        wait_drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d buffers (%0d framed words) plus stray and restart cases,",
                 frames_sent, bytes_sent);
        $display("%0d output words matched under four idling mixes and a long output hold",
                 sb.matched);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("length_prefixed_nal_to_start_codes test passed");
        else
            $display("length_prefixed_nal_to_start_codes test failed");
        $finish;
    end

endmodule

FILE: length_prefixed_nal_to_start_codes.f
src/lpn_pkg.sv
src/lpn_front.sv
src/lpn_queue.sv
src/lpn_back.sv
src/length_prefixed_nal_to_start_codes.sv
bench/length_prefixed_nal_to_start_codes_tb.sv
